// ===== hw/rtl/qalu_pkg.sv =====
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared types, codes and lane tables for the quaternion ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package qalu_pkg;

	// Fixed frame of the magnitude path: the sum of squares is scaled into 64 bits
	localparam int T_W      = 64;
	localparam int RT_W     = T_W / 2;     // square root width
	localparam int NV_W     = RT_W + 1;    // scaled component, signed
	localparam int NCOMP    = 4;
	// Stages from input to magnitude result: squares, sum, two count stages,
	// shift, then one stage per root bit
	localparam int NORM_LAT = 5 + RT_W;

	typedef enum logic [2:0] {
		MODE_ADD      = 3'd0,
		MODE_SUB      = 3'd1,
		MODE_MUL      = 3'd2,
		MODE_MUL_CONJ = 3'd3,
		MODE_NORM     = 3'd4,
		MODE_CONJ     = 3'd5
	} mode_t;

	// Magnitude unit result handed to every lane
	typedef struct packed {
		logic [RT_W-1:0]                 root;
		logic [NCOMP-1:0][NV_W-1:0]      scaled;
		logic                            zero;
	} norm_t;

	// Per-lane status handed to the merge stage
	typedef struct packed {
		logic sat;
		logic zero;
	} lane_stat_t;

	// Hamilton product terms: operand indexes and sign, per lane and term
	localparam logic [1:0] A_SEL [NCOMP][NCOMP] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	localparam logic [1:0] B_SEL [NCOMP][NCOMP] = '{
		'{2'd3, 2'd2, 2'd1, 2'd0},
		'{2'd2, 2'd3, 2'd0, 2'd1},
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	localparam logic NEG_TERM [NCOMP][NCOMP] = '{
		'{1'b0, 1'b0, 1'b1, 1'b0},
		'{1'b1, 1'b0, 1'b0, 1'b0},
		'{1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, 1'b1, 1'b1, 1'b1}
	};
	localparam logic [1:0] SCALAR_IDX = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/qalu_in_if.sv =====
// ----------------------------------------------------------------------------
// qalu_in_if
// Operand word channel: mode and two quaternions.
// ----------------------------------------------------------------------------
`default_nettype none

interface qalu_in_if #(parameter int CW = 16);
	logic                 valid;
	logic                 ready;
	logic [2:0]           mode;
	logic signed [CW-1:0] a_x;
	logic signed [CW-1:0] a_y;
	logic signed [CW-1:0] a_z;
	logic signed [CW-1:0] a_w;
	logic signed [CW-1:0] b_x;
	logic signed [CW-1:0] b_y;
	logic signed [CW-1:0] b_z;
	logic signed [CW-1:0] b_w;

	modport source (output valid, mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
		input ready);
	modport sink (input valid, mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/qalu_out_if.sv =====
// ----------------------------------------------------------------------------
// qalu_out_if
// Result word channel: one quaternion and two flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface qalu_out_if #(parameter int CW = 16);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] r_x;
	logic signed [CW-1:0] r_y;
	logic signed [CW-1:0] r_z;
	logic signed [CW-1:0] r_w;
	logic                 saturated;
	logic                 zero_magnitude;

	modport source (output valid, r_x, r_y, r_z, r_w, saturated, zero_magnitude,
		input ready);
	modport sink (input valid, r_x, r_y, r_z, r_w, saturated, zero_magnitude,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/qalu_norm.sv =====
// ----------------------------------------------------------------------------
// qalu_norm
// Magnitude unit: sum of squares, scaling into the 64-bit frame and a
// pipelined square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_norm #(
	parameter int CW = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic [qalu_pkg::NCOMP-1:0][CW-1:0]   a,
	output qalu_pkg::norm_t                           norm
);
	localparam int NC   = qalu_pkg::NCOMP;
	localparam int TW   = qalu_pkg::T_W;
	localparam int RW   = qalu_pkg::RT_W;
	localparam int NW   = qalu_pkg::NV_W;
	localparam int SW   = TW + 2;
	localparam int RMW  = RW + 4;
	localparam int NGRP = TW / 8;

	// Stage 1: squares
	logic [2*CW-1:0]          sq_s1 [NC];
	logic [NC-1:0][CW-1:0]    a_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NC; i++) begin
				sq_s1[i] <= (2*CW)'($signed(a[i]) * $signed(a[i]));
			end
			a_s1 <= a;
		end
	end

	// Stage 2: exact sum of squares
	logic [SW-1:0]            sum_s2;
	logic [NC-1:0][CW-1:0]    a_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= SW'(sq_s1[0]) + SW'(sq_s1[1]) + SW'(sq_s1[2]) + SW'(sq_s1[3]);
			a_s2   <= a_s1;
		end
	end

	// Stage 3: overflow of the 64-bit frame, zero test, per-byte leading zeros
	logic [NGRP-1:0]          gnz_c;
	logic [3:0]               glz_c [NGRP];
	logic [NGRP-1:0]          gnz_s3;
	logic [3:0]               glz_s3 [NGRP];
	logic [TW-1:0]            t0_s3;
	logic                     carry_s3;
	logic                     zero_s3;
	logic [NC-1:0][CW-1:0]    a_s3;

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			gnz_c[g] = |sum_s2[g*8 +: 8];
			glz_c[g] = 4'd8;
			for (int k = 0; k < 8; k++) begin
				if (sum_s2[g*8 + k]) begin
					glz_c[g] = 4'(7 - k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gnz_s3   <= gnz_c;
			glz_s3   <= glz_c;
			carry_s3 <= |sum_s2[SW-1:TW];
			zero_s3  <= (sum_s2 == '0);
			t0_s3    <= (|sum_s2[SW-1:TW]) ? sum_s2[SW-1:2] : sum_s2[TW-1:0];
			a_s3     <= a_s2;
		end
	end

	// Stage 4: pick the leading byte, halve the count into a shift by pairs
	logic [6:0]               lz_c;
	logic [4:0]               k_s4;
	logic [TW-1:0]            t0_s4;
	logic                     carry_s4;
	logic                     zero_s4;
	logic [NC-1:0][CW-1:0]    a_s4;

	always_comb begin
		lz_c = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (gnz_s3[g]) begin
				lz_c = 7'((NGRP - 1 - g) * 8) + 7'(glz_s3[g]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s4     <= lz_c[5:1];
			t0_s4    <= t0_s3;
			carry_s4 <= carry_s3;
			zero_s4  <= zero_s3;
			a_s4     <= a_s3;
		end
	end

	// Stage 5: scale radicand by four to the k, components by two to the k or, on overflow, by half
	logic [NW-1:0]            n_c [NC];
	logic [CW:0]              half_c [NC];
	logic [TW-1:0]            wide_c [NC];

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			half_c[i] = (CW+1)'($signed(a_s4[i])) + {{CW{1'b0}}, a_s4[i][CW-1]};
			wide_c[i] = TW'($signed(a_s4[i])) << k_s4;
			if (carry_s4) begin
				n_c[i] = NW'($signed(half_c[i][CW:1]));
			end else begin
				n_c[i] = wide_c[i][NW-1:0];
			end
		end
	end

	// Square root pipeline, entry zero is stage 5
	logic [TW-1:0]            rad_q  [RW+1];
	logic [RMW-1:0]           rem_q  [RW+1];
	logic [RW-1:0]            root_q [RW+1];
	logic [NC-1:0][NW-1:0]    n_q    [RW+1];
	logic                     zero_q [RW+1];
	logic [RMW-1:0]           cur_c  [RW];
	logic [RMW-1:0]           trial_c[RW];
	logic                     ge_c   [RW];

	always_comb begin
		for (int i = 0; i < RW; i++) begin
			cur_c[i]   = {rem_q[i][RMW-3:0], rad_q[i][TW-1 -: 2]};
			trial_c[i] = RMW'({root_q[i], 2'b01});
			ge_c[i]    = (cur_c[i] >= trial_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q[0]  <= carry_s4 ? t0_s4 : (t0_s4 << {k_s4, 1'b0});
			rem_q[0]  <= '0;
			root_q[0] <= '0;
			for (int i = 0; i < NC; i++) begin
				n_q[0][i] <= n_c[i];
			end
			zero_q[0] <= zero_s4;
			for (int i = 0; i < RW; i++) begin
				rad_q[i+1]  <= rad_q[i] << 2;
				rem_q[i+1]  <= ge_c[i] ? (cur_c[i] - trial_c[i]) : cur_c[i];
				root_q[i+1] <= {root_q[i][RW-2:0], ge_c[i]};
				n_q[i+1]    <= n_q[i];
				zero_q[i+1] <= zero_q[i];
			end
		end
	end

	assign norm.root   = root_q[RW];
	assign norm.scaled = n_q[RW];
	assign norm.zero   = zero_q[RW];

endmodule

`default_nettype wire

// ===== hw/rtl/qalu_lane.sv =====
// ----------------------------------------------------------------------------
// qalu_lane
// One result component: four products with rounding, component add, subtract
// and conjugate, a pipelined divider for normalize, and the final clip.
// ----------------------------------------------------------------------------
`default_nettype none

module qalu_lane #(
	parameter int CW   = 16,
	parameter int FB   = 14,
	parameter int LANE = 0
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic [2:0]                           mode,
	input  wire logic [qalu_pkg::NCOMP-1:0][CW-1:0]   a,
	input  wire logic [qalu_pkg::NCOMP-1:0][CW-1:0]   b,
	input  qalu_pkg::norm_t                           norm,
	output logic signed [CW-1:0]                      res,
	output qalu_pkg::lane_stat_t                      stat
);
	localparam int NC   = qalu_pkg::NCOMP;
	localparam int NW   = qalu_pkg::NV_W;
	localparam int RW   = qalu_pkg::RT_W;
	localparam int PW   = 2 * CW;
	localparam int SUMW = 2 * CW + 3;
	localparam int QW   = FB + 1;
	localparam int DVW  = NW + FB + 2;
	localparam int DLY  = qalu_pkg::NORM_LAT + QW - 1;
	localparam logic signed [SUMW-1:0] HALF = SUMW'(1) << (FB - 1);
	localparam logic [1:0] LIDX = 2'(LANE);

	// Stage 1: products and the direct component result
	logic signed [PW-1:0]  prod_c [NC];
	logic [NC-1:0]         neg_c;
	logic signed [CW:0]    dir_c;
	logic signed [PW-1:0]  prod_s1 [NC];
	logic [NC-1:0]         neg_s1;
	logic signed [CW:0]    dir_s1;
	logic [2:0]            mode_s1;

	always_comb begin
		for (int j = 0; j < NC; j++) begin
			prod_c[j] = $signed(a[qalu_pkg::A_SEL[LANE][j]])
				* $signed(b[qalu_pkg::B_SEL[LANE][j]]);
			neg_c[j] = qalu_pkg::NEG_TERM[LANE][j]
				^ ((mode == qalu_pkg::MODE_MUL_CONJ)
				&& (qalu_pkg::B_SEL[LANE][j] != qalu_pkg::SCALAR_IDX));
		end
		unique case (mode)
			qalu_pkg::MODE_ADD: begin
				dir_c = (CW+1)'($signed(a[LIDX])) + (CW+1)'($signed(b[LIDX]));
			end
			qalu_pkg::MODE_SUB: begin
				dir_c = (CW+1)'($signed(a[LIDX])) - (CW+1)'($signed(b[LIDX]));
			end
			qalu_pkg::MODE_CONJ: begin
				if (LIDX == qalu_pkg::SCALAR_IDX) begin
					dir_c = (CW+1)'($signed(b[LIDX]));
				end else begin
					dir_c = -(CW+1)'($signed(b[LIDX]));
				end
			end
			default: begin
				dir_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_c;
			neg_s1  <= neg_c;
			dir_s1  <= dir_c;
			mode_s1 <= mode;
		end
	end

	// Stage 2: exact sum, round to nearest with ties up, select by mode
	logic signed [SUMW-1:0] sum_c;
	logic signed [SUMW-1:0] biased_c;
	logic signed [SUMW-1:0] rnd_c;
	logic signed [SUMW-1:0] wres_c;

	always_comb begin
		sum_c = '0;
		for (int j = 0; j < NC; j++) begin
			if (neg_s1[j]) begin
				sum_c = sum_c - SUMW'(prod_s1[j]);
			end else begin
				sum_c = sum_c + SUMW'(prod_s1[j]);
			end
		end
		biased_c = sum_c + HALF;
		rnd_c    = biased_c >>> FB;
		if ((mode_s1 == qalu_pkg::MODE_MUL) || (mode_s1 == qalu_pkg::MODE_MUL_CONJ)) begin
			wres_c = rnd_c;
		end else begin
			wres_c = SUMW'(dir_s1);
		end
	end

	// Delay line: hold the direct or product result and the mode until the divider finishes
	logic signed [SUMW-1:0] wres_q [DLY+1];
	logic [2:0]             mode_q [DLY+1];

	always_ff @(posedge clk) begin
		if (en) begin
			wres_q[0] <= wres_c;
			mode_q[0] <= mode_s1;
			for (int i = 1; i <= DLY; i++) begin
				wres_q[i] <= wres_q[i-1];
				mode_q[i] <= mode_q[i-1];
			end
		end
	end

	// Divider: one quotient bit per stage, entry zero forms the rounded numerator
	logic signed [NW-1:0] n_c;
	logic [NW-1:0]        mag_c;
	logic [DVW-1:0]       rem_q  [QW+1];
	logic [DVW-1:0]       dv_q   [QW+1];
	logic [QW-1:0]        quo_q  [QW+1];
	logic                 sgn_q  [QW+1];
	logic                 zero_q [QW+1];
	logic [DVW-1:0]       shd_c  [QW];
	logic                 ge_c   [QW];

	always_comb begin
		n_c   = $signed(norm.scaled[LIDX]);
		mag_c = n_c[NW-1] ? NW'(-n_c) : NW'(n_c);
		for (int i = 0; i < QW; i++) begin
			shd_c[i] = dv_q[i] << (QW - 1 - i);
			ge_c[i]  = (rem_q[i] >= shd_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= (DVW'(mag_c) << (FB + 1)) + DVW'(norm.root);
			dv_q[0]   <= DVW'({norm.root, 1'b0});
			quo_q[0]  <= '0;
			sgn_q[0]  <= n_c[NW-1];
			zero_q[0] <= norm.zero;
			for (int i = 0; i < QW; i++) begin
				rem_q[i+1]  <= ge_c[i] ? (rem_q[i] - shd_c[i]) : rem_q[i];
				dv_q[i+1]   <= dv_q[i];
				quo_q[i+1]  <= {quo_q[i][QW-2:0], ge_c[i]};
				sgn_q[i+1]  <= sgn_q[i];
				zero_q[i+1] <= zero_q[i];
			end
		end
	end

	// Final stage: pick the result and clip it to the component format
	logic signed [SUMW-1:0] nres_c;
	logic signed [SUMW-1:0] fin_c;
	logic                   fits_c;
	logic                   is_norm_c;

	always_comb begin
		is_norm_c = (mode_q[DLY] == qalu_pkg::MODE_NORM);
		if (zero_q[QW]) begin
			nres_c = '0;
		end else if (sgn_q[QW]) begin
			nres_c = -SUMW'(quo_q[QW]);
		end else begin
			nres_c = SUMW'(quo_q[QW]);
		end
		fin_c  = is_norm_c ? nres_c : wres_q[DLY];
		fits_c = (&fin_c[SUMW-1:CW-1]) || !(|fin_c[SUMW-1:CW-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat <= '0;
		end else if (en) begin
			stat.sat  <= !fits_c;
			stat.zero <= is_norm_c && zero_q[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fits_c) begin
				res <= fin_c[CW-1:0];
			end else begin
				res <= {fin_c[SUMW-1], {(CW-1){!fin_c[SUMW-1]}}};
			end
		end
	end

	// Width check on the root frame
	logic unused_ok;
	assign unused_ok = (RW == NW - 1);

	property p_frame_ok;
		@(posedge clk) disable iff (!arst_n) unused_ok;
	endproperty
	a_frame_ok: assert property (p_frame_ok) else $error("root frame width mismatch");

endmodule

`default_nettype wire

// ===== hw/rtl/quaternion_alu_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_alu_core
// Quaternion ALU: add, subtract, Hamilton product, product with conjugate,
// normalize and conjugate, with saturation, in four component lanes.
// ----------------------------------------------------------------------------
//  channel | direction | word
//  --------+-----------+-------------------------------------------------------
//  req     | in        | mode, a_x a_y a_z a_w, b_x b_y b_z b_w
//  rsp     | out       | r_x r_y r_z r_w, saturated, zero_magnitude
//
//  One word per cycle while rsp is not stalled; each word runs from req
//  to rsp through the 32-stage square root and the divider that makes
//  one quotient bit per stage.
//  Reset clears the valid bits of the pipeline and the status flags.
//  A held result on rsp freezes the whole pipeline; a bubble in the last
//  stage is filled while rsp stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_alu_core #(
	parameter int COMPONENT_WIDTH = 16,
	parameter int FRACTION_BITS   = 14
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	qalu_in_if.sink       req,
	qalu_out_if.source    rsp
);
	localparam int CW  = COMPONENT_WIDTH;
	localparam int NC  = qalu_pkg::NCOMP;
	localparam int LAT = qalu_pkg::NORM_LAT + FRACTION_BITS + 4;

	logic                         en;
	logic [LAT-1:0]               vld_q;
	logic [NC-1:0][CW-1:0]        a_vec;
	logic [NC-1:0][CW-1:0]        b_vec;
	qalu_pkg::norm_t              norm;
	logic signed [CW-1:0]         lres [NC];
	qalu_pkg::lane_stat_t         lstat [NC];

	// Advance unless the last word is held
	assign en        = !vld_q[LAT-1] || rsp.ready;
	assign req.ready = en;
	assign rsp.valid = vld_q[LAT-1];

	assign a_vec = {req.a_w, req.a_z, req.a_y, req.a_x};
	assign b_vec = {req.b_w, req.b_z, req.b_y, req.b_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], req.valid};
		end
	end

	qalu_norm #(.CW(CW)) u_norm (
		.clk    (clk),
		.en     (en),
		.a      (a_vec),
		.norm   (norm)
	);

	for (genvar l = 0; l < NC; l++) begin : g_lane
		qalu_lane #(.CW(CW), .FB(FRACTION_BITS), .LANE(l)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.mode   (req.mode),
			.a      (a_vec),
			.b      (b_vec),
			.norm   (norm),
			.res    (lres[l]),
			.stat   (lstat[l])
		);
	end

	// Merge the lanes into the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.saturated      <= 1'b0;
			rsp.zero_magnitude <= 1'b0;
		end else if (en) begin
			rsp.saturated      <= lstat[0].sat | lstat[1].sat | lstat[2].sat | lstat[3].sat;
			rsp.zero_magnitude <= lstat[0].zero | lstat[1].zero | lstat[2].zero
				| lstat[3].zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.r_x <= lres[0];
			rsp.r_y <= lres[1];
			rsp.r_z <= lres[2];
			rsp.r_w <= lres[3];
		end
	end

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.saturated && rsp.zero_magnitude))
		else $error("saturated and zero_magnitude both set");

	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.zero_magnitude) |->
		(rsp.r_x == '0 && rsp.r_y == '0 && rsp.r_z == '0 && rsp.r_w == '0))
		else $error("zero magnitude word carries a nonzero component");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.saturated) |->
		(rsp.r_x == CMAX || rsp.r_x == CMIN || rsp.r_y == CMAX || rsp.r_y == CMIN
		|| rsp.r_z == CMAX || rsp.r_z == CMIN || rsp.r_w == CMAX || rsp.r_w == CMIN))
		else $error("saturated word has no component at a bound");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams operand words through quaternion_alu_core and checks every result
// word against a behavioral model of the six modes. The model covers
// saturation, product rounding and the normalize magnitude path. The run
// steps through directed corner words, random words under several
// sender/receiver idle mixes, and a long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CW        = 16;
	localparam int  FB        = 14;
	localparam int  PIPE_LAT  = 41 + FB;
	localparam int  CYCLE_CAP = 400000;
	localparam logic signed [CW-1:0] Q_MAX = 16'sh7fff;
	localparam logic signed [CW-1:0] Q_MIN = -16'sh8000;
	localparam logic signed [CW-1:0] Q_ONE = 16'sh4000;

	typedef struct {
		logic [2:0]           mode;
		logic signed [CW-1:0] a [4];
		logic signed [CW-1:0] b [4];
	} op_word_t;

	typedef struct {
		logic signed [CW-1:0] r [4];
		logic                 sat;
		logic                 zero;
	} quat_result_t;

	logic clk;
	logic arst_n;

	qalu_in_if  #(.CW(CW)) req_if ();
	qalu_out_if #(.CW(CW)) rsp_if ();

	quaternion_alu_core #(
		.COMPONENT_WIDTH(CW),
		.FRACTION_BITS(FB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	quat_result_t pending_results[$];
	int           error_count;
	int           sender_idle_pct;
	int           sink_stall_pct;
	int           hold_left;
	longint       cycle_count;

	// Clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Integer square root, floor
	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = '0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Scale an exact product sum down by the fraction bits, nearest, ties up
	function automatic longint round_frac(longint s);
		return (s + (longint'(1) <<< (FB - 1))) >>> FB;
	endfunction

	// Expected result word for one operand word
	function automatic quat_result_t quat_alu_result(op_word_t w);
		quat_result_t res;
		longint       av [4];
		longint       bv [4];
		longint       rv [4];
		longint       nv;
		logic [63:0]  sumsq;
		logic [63:0]  mag;
		logic [63:0]  root;
		logic [63:0]  quo;
		int           shift;
		res.sat  = 1'b0;
		res.zero = 1'b0;
		for (int i = 0; i < 4; i++) begin
			av[i] = w.a[i];
			bv[i] = w.b[i];
			rv[i] = 0;
		end
		case (w.mode)
			qalu_pkg::MODE_ADD: begin
				for (int i = 0; i < 4; i++) rv[i] = av[i] + bv[i];
			end
			qalu_pkg::MODE_SUB: begin
				for (int i = 0; i < 4; i++) rv[i] = av[i] - bv[i];
			end
			qalu_pkg::MODE_MUL, qalu_pkg::MODE_MUL_CONJ: begin
				// conjugate of b is exact, no clipping before the product
				if (w.mode == qalu_pkg::MODE_MUL_CONJ)
					for (int i = 0; i < 3; i++) bv[i] = -bv[i];
				rv[0] = round_frac(av[0]*bv[3] + av[1]*bv[2] - av[2]*bv[1] + av[3]*bv[0]);
				rv[1] = round_frac(-av[0]*bv[2] + av[1]*bv[3] + av[2]*bv[0] + av[3]*bv[1]);
				rv[2] = round_frac(av[0]*bv[1] - av[1]*bv[0] + av[2]*bv[3] + av[3]*bv[2]);
				rv[3] = round_frac(av[3]*bv[3] - av[0]*bv[0] - av[1]*bv[1] - av[2]*bv[2]);
			end
			qalu_pkg::MODE_NORM: begin
				sumsq = '0;
				for (int i = 0; i < 4; i++) sumsq = sumsq + 64'(av[i] * av[i]);
				if (sumsq == 0) begin
					res.zero = 1'b1;
				end else begin
					// scale by a power of four into the top of 64 bits
					shift = 0;
					while (sumsq < 64'h4000_0000_0000_0000) begin
						sumsq = sumsq << 2;
						shift++;
					end
					root = floor_sqrt(sumsq);
					for (int i = 0; i < 4; i++) begin
						nv    = av[i] <<< shift;
						mag   = (nv < 0) ? 64'(-nv) : 64'(nv);
						quo   = ((mag << (FB + 1)) + root) / (root << 1);
						rv[i] = (nv < 0) ? -longint'(quo) : longint'(quo);
					end
				end
			end
			qalu_pkg::MODE_CONJ: begin
				rv[0] = -bv[0];
				rv[1] = -bv[1];
				rv[2] = -bv[2];
				rv[3] = bv[3];
			end
			default: ;
		endcase
		// clip to the component range
		for (int i = 0; i < 4; i++) begin
			if (rv[i] > longint'(Q_MAX)) begin
				rv[i]   = Q_MAX;
				res.sat = 1'b1;
			end else if (rv[i] < longint'(Q_MIN)) begin
				rv[i]   = Q_MIN;
				res.sat = 1'b1;
			end
			res.r[i] = rv[i][CW-1:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		error_count++;
	endtask

	// Check each accepted result word against the oldest expectation
	always @(posedge clk) begin
		quat_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.r_x !== want.r[0]) report_mismatch("r_x", rsp_if.r_x, want.r[0]);
				if (rsp_if.r_y !== want.r[1]) report_mismatch("r_y", rsp_if.r_y, want.r[1]);
				if (rsp_if.r_z !== want.r[2]) report_mismatch("r_z", rsp_if.r_z, want.r[2]);
				if (rsp_if.r_w !== want.r[3]) report_mismatch("r_w", rsp_if.r_w, want.r[3]);
				if (rsp_if.saturated !== want.sat)
					report_mismatch("saturated", rsp_if.saturated, want.sat);
				if (rsp_if.zero_magnitude !== want.zero)
					report_mismatch("zero_magnitude", rsp_if.zero_magnitude, want.zero);
			end
		end
	end

	// Drive receiver ready: long hold-off first, then random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_if.ready = 1'b0;
			hold_left--;
		end else begin
			rsp_if.ready = !(sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct);
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// Send one operand word; called and returns at a falling edge
	task automatic send_word(op_word_t w);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid = 1'b1;
		req_if.mode  = w.mode;
		req_if.a_x   = w.a[0];
		req_if.a_y   = w.a[1];
		req_if.a_z   = w.a[2];
		req_if.a_w   = w.a[3];
		req_if.b_x   = w.b[0];
		req_if.b_y   = w.b[1];
		req_if.b_z   = w.b[2];
		req_if.b_w   = w.b[3];
		do @(posedge clk); while (!req_if.ready);
		pending_results.push_back(quat_alu_result(w));
		@(negedge clk);
	endtask

	task automatic send_quat(logic [2:0] mode, logic signed [CW-1:0] ax, ay, az, aw,
			logic signed [CW-1:0] bx, by, bz, bw);
		op_word_t w;
		w.mode = mode;
		w.a = '{ax, ay, az, aw};
		w.b = '{bx, by, bz, bw};
		send_word(w);
	endtask

	// Hold the sender until every expected word has come back
	task automatic drain_results();
		req_if.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Component value biased toward extremes, unit and tiny values
	function automatic logic signed [CW-1:0] pick_component();
		case ($urandom_range(7))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return $urandom_range(1) ? Q_ONE : -Q_ONE;
			4: return CW'($urandom_range(7)) - CW'(3);
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic op_word_t random_word();
		op_word_t w;
		w.mode = 3'($urandom_range(qalu_pkg::MODE_CONJ));
		for (int i = 0; i < 4; i++) begin
			w.a[i] = pick_component();
			w.b[i] = pick_component();
		end
		// all-zero a now and then for normalize
		if (w.mode == qalu_pkg::MODE_NORM && $urandom_range(9) == 0)
			w.a = '{4{CW'(0)}};
		return w;
	endfunction

	task automatic test_add_sub();
		send_quat(qalu_pkg::MODE_ADD, Q_MAX, Q_MIN, 1, -1, Q_MAX, Q_MIN, -1, 1);
		send_quat(qalu_pkg::MODE_ADD, Q_MAX, 0, Q_ONE, -Q_ONE, 0, Q_MIN, Q_ONE, -Q_ONE);
		send_quat(qalu_pkg::MODE_SUB, Q_MIN, Q_MAX, 5, 0, Q_MAX, Q_MIN, 7, 0);
		send_quat(qalu_pkg::MODE_SUB, 100, -100, Q_ONE, Q_MIN, 99, -101, Q_ONE, 0);
	endtask

	task automatic test_products();
		// i*j = k, j*i = -k
		send_quat(qalu_pkg::MODE_MUL, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0);
		send_quat(qalu_pkg::MODE_MUL, 0, Q_ONE, 0, 0, Q_ONE, 0, 0, 0);
		send_quat(qalu_pkg::MODE_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_quat(qalu_pkg::MODE_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
			Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		// rounding ties on half an lsb
		send_quat(qalu_pkg::MODE_MUL, 1, 0, 0, 1, 0, 0, 0, 8192);
		send_quat(qalu_pkg::MODE_MUL, -1, 0, 0, -1, 0, 0, 0, 8192);
		send_quat(qalu_pkg::MODE_MUL_CONJ, Q_ONE, Q_ONE, 0, 0, Q_ONE, Q_ONE, 0, 0);
		send_quat(qalu_pkg::MODE_MUL_CONJ, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			Q_MIN, Q_MIN, Q_MIN, Q_MIN);
	endtask

	task automatic test_normalize();
		send_quat(qalu_pkg::MODE_NORM, 0, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send_quat(qalu_pkg::MODE_NORM, 1, 0, 0, 0, 0, 0, 0, 0);
		send_quat(qalu_pkg::MODE_NORM, 0, 0, 0, -1, 0, 0, 0, 0);
		send_quat(qalu_pkg::MODE_NORM, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 0);
		send_quat(qalu_pkg::MODE_NORM, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0);
		send_quat(qalu_pkg::MODE_NORM, 3, -4, 0, 12, 0, 0, 0, 0);
	endtask

	task automatic test_conjugate();
		send_quat(qalu_pkg::MODE_CONJ, 0, 0, 0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_quat(qalu_pkg::MODE_CONJ, 0, 0, 0, 0, Q_MAX, -Q_ONE, 1, Q_MIN);
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		sender_idle_pct = idle_pct;
		sink_stall_pct  = stall_pct;
		repeat (count) send_word(random_word());
		drain_results();
	endtask

	// Receiver holds off long enough for the pipeline to fill and stall req
	task automatic test_hold_off();
		sender_idle_pct = 0;
		sink_stall_pct  = 0;
		hold_left       = 4 * PIPE_LAT;
		repeat (150) send_word(random_word());
		drain_results();
	endtask

	initial begin
		error_count     = 0;
		cycle_count     = 0;
		hold_left       = 0;
		sender_idle_pct = 0;
		sink_stall_pct  = 0;
		arst_n          = 1'b0;
		rsp_if.ready    = 1'b1;
		req_if.valid    = 1'b0;
		req_if.mode     = qalu_pkg::MODE_ADD;
		req_if.a_x      = '0;
		req_if.a_y      = '0;
		req_if.a_z      = '0;
		req_if.a_w      = '0;
		req_if.b_x      = '0;
		req_if.b_y      = '0;
		req_if.b_z      = '0;
		req_if.b_w      = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_add_sub();
		test_products();
		test_normalize();
		test_conjugate();
		drain_results();
		test_random(450, 0, 0);
		test_random(450, 48, 0);
		test_random(450, 0, 48);
		test_random(450, 9, 9);
		test_hold_off();

		repeat (PIPE_LAT + 20) @(negedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== quaternion_alu_core.f =====
hw/rtl/qalu_pkg.sv
hw/rtl/qalu_in_if.sv
hw/rtl/qalu_out_if.sv
hw/rtl/qalu_norm.sv
hw/rtl/qalu_lane.sv
hw/rtl/quaternion_alu_core.sv
tb/testbench.sv
